>>> rtl/tpsa_pkg.sv
package tpsa_pkg;

    // Pool size and the widths that follow from it. A link equal to the pool
    // size means no unit.
    localparam int MAX_UNITS = 1024;
    localparam int ID_W      = $clog2(MAX_UNITS);
    localparam int LINK_W    = ID_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_UNITS);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ID   = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_WAS_FREE = 2'd3;

    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_FREE   = 1'b1;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_IDLE    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_DECIDE  = 4'd2;
    localparam logic [3:0] OP_RD_UNIT = 4'd3;
    localparam logic [3:0] OP_UNLINK  = 4'd4;
    localparam logic [3:0] OP_RESULT  = 4'd5;

    typedef struct packed {
        logic [3:0] op;
    } tpsa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic error;
        logic is_free;
    } tpsa_stat_t;

endpackage

>>> rtl/tpsa_ctrl.sv
module tpsa_ctrl
    import tpsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       cfg_write,
    input  tpsa_stat_t stat,
    output tpsa_cmd_t  cmd,
    output logic       busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_RDU    = 3'd3;
    localparam logic [2:0] S_UNL    = 3'd4;
    localparam logic [2:0] S_RES    = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.op = OP_DECIDE;
                if (stat.error)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_RDU;
                end
            end
            S_RDU:
            begin
                // A free finishes here; an assign goes on to unlink its unit.
                cmd.op = OP_RD_UNIT;
                if (stat.is_free)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_UNL;
                end
            end
            S_UNL:
            begin
                cmd.op     = OP_UNLINK;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.op     = OP_RESULT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            state_next = S_CLEAR;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/tpsa_dp.sv
module tpsa_dp
    import tpsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start_ok,
    input  logic              req_type,
    input  logic [ID_W-1:0]   unit_id,
    input  logic              unit_kind,
    input  logic              cfg_write,
    input  logic [LINK_W-1:0] cfg_data,
    input  tpsa_cmd_t         cmd,
    output tpsa_stat_t        stat,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   granted_id,
    output logic [LINK_W-1:0] count_kind_a,
    output logic [LINK_W-1:0] count_kind_b
);

    // Per-unit state is split over three memories so that one step can update
    // a unit's flags and the links of two different neighbors together.
    logic [1:0]        meta_mem [MAX_UNITS];
    logic [LINK_W-1:0] next_mem [MAX_UNITS];
    logic [LINK_W-1:0] prev_mem [MAX_UNITS];

    logic [LINK_W-1:0] active_reg;
    logic [ID_W-1:0]   clr_reg;
    logic              req_reg;
    logic [ID_W-1:0]   id_reg;
    logic              kind_reg;
    logic [LINK_W-1:0] head_reg [2];
    logic [LINK_W-1:0] tail_reg [2];
    logic [LINK_W-1:0] cnt_reg  [2];
    logic [ID_W-1:0]   u_reg;
    logic [1:0]        st_reg;
    logic              grant_reg;
    logic              out_v_reg;
    logic [1:0]        out_st_reg;
    logic [ID_W-1:0]   out_id_reg;

    logic [1:0]        rd_meta;
    logic [LINK_W-1:0] rd_next;
    logic [LINK_W-1:0] rd_prev;
    logic              rd_taken;
    logic              rd_type;

    logic [ID_W-1:0]   rd_addr;
    logic              meta_we;
    logic              next_we;
    logic              prev_we;
    logic [ID_W-1:0]   meta_wa;
    logic [ID_W-1:0]   next_wa;
    logic [ID_W-1:0]   prev_wa;
    logic [1:0]        meta_wd;
    logic [LINK_W-1:0] next_wd;
    logic [LINK_W-1:0] prev_wd;

    logic [LINK_W-1:0] cfg_sat;
    logic [LINK_W-1:0] clr_ext;
    logic              id_bad;
    logic              none_free;
    logic              src;
    logic [LINK_W-1:0] src_head;

    assign rd_taken  = rd_meta[1];
    assign rd_type   = rd_meta[0];
    assign cfg_sat   = (cfg_data == '0) ? LINK_W'(1) :
                       ((cfg_data > LINK_W'(MAX_UNITS)) ? LINK_W'(MAX_UNITS) : cfg_data);
    assign clr_ext   = {1'b0, clr_reg};
    assign id_bad    = ({1'b0, id_reg} >= active_reg);
    assign none_free = (head_reg[0] == NIL_LINK) && (head_reg[1] == NIL_LINK);
    assign src       = (head_reg[kind_reg] != NIL_LINK) ? kind_reg : ~kind_reg;
    assign src_head  = head_reg[src];

    // The requested unit is read in DECIDE. If an assign finds it taken, the
    // head of the source list is read instead, so UNLINK always sees its unit.
    always_comb
    begin
        rd_addr = id_reg;
        if (cmd.op == OP_RD_UNIT && req_reg == REQ_ASSIGN && rd_taken)
        begin
            rd_addr = src_head[ID_W-1:0];
        end
    end

    always_comb
    begin
        meta_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        meta_wa = u_reg;
        next_wa = u_reg;
        prev_wa = u_reg;
        meta_wd = 2'b00;
        next_wd = NIL_LINK;
        prev_wd = NIL_LINK;
        case (cmd.op)
            OP_CLEAR:
            begin
                meta_we = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                meta_wa = clr_reg;
                next_wa = clr_reg;
                prev_wa = clr_reg;
                if (clr_ext + LINK_W'(1) < active_reg)
                begin
                    next_wd = clr_ext + LINK_W'(1);
                end
                if (clr_reg != '0 && clr_ext < active_reg)
                begin
                    prev_wd = clr_ext - LINK_W'(1);
                end
            end
            OP_RD_UNIT:
            begin
                // Release: append behind the tail of the unit's own list.
                if (req_reg == REQ_FREE && rd_taken)
                begin
                    meta_we = 1'b1;
                    meta_wa = id_reg;
                    meta_wd = {1'b0, rd_type};
                    prev_we = 1'b1;
                    prev_wa = id_reg;
                    if (head_reg[rd_type] != NIL_LINK)
                    begin
                        prev_wd = tail_reg[rd_type];
                        next_we = 1'b1;
                        next_wa = tail_reg[rd_type][ID_W-1:0];
                        next_wd = {1'b0, id_reg};
                    end
                end
            end
            OP_UNLINK:
            begin
                meta_we = 1'b1;
                meta_wd = {1'b1, kind_reg};
                if (rd_prev != NIL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = rd_prev[ID_W-1:0];
                    next_wd = rd_next;
                end
                if (rd_next != NIL_LINK)
                begin
                    prev_we = 1'b1;
                    prev_wa = rd_next[ID_W-1:0];
                    prev_wd = rd_prev;
                end
            end
            OP_RESULT:
            begin
                // A granted unit leaves with both of its links null.
                if (grant_reg)
                begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
            end
            default:
            begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        rd_meta <= meta_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= LINK_W'(MAX_UNITS);
            clr_reg     <= '0;
            req_reg     <= REQ_ASSIGN;
            id_reg      <= '0;
            kind_reg    <= 1'b0;
            head_reg[0] <= '0;
            head_reg[1] <= NIL_LINK;
            tail_reg[0] <= LINK_W'(MAX_UNITS - 1);
            tail_reg[1] <= NIL_LINK;
            cnt_reg[0]  <= LINK_W'(MAX_UNITS);
            cnt_reg[1]  <= '0;
            u_reg       <= '0;
            st_reg      <= ST_OK;
            grant_reg   <= 1'b0;
            out_v_reg   <= 1'b0;
            out_st_reg  <= ST_OK;
            out_id_reg  <= '0;
        end
        else
        begin
            out_v_reg <= 1'b0;
            if (cfg_write)
            begin
                active_reg  <= cfg_sat;
                clr_reg     <= '0;
                head_reg[0] <= '0;
                head_reg[1] <= NIL_LINK;
                tail_reg[0] <= cfg_sat - LINK_W'(1);
                tail_reg[1] <= NIL_LINK;
                cnt_reg[0]  <= cfg_sat;
                cnt_reg[1]  <= '0;
            end
            else
            begin
                case (cmd.op)
                    OP_CLEAR:
                    begin
                        clr_reg <= clr_reg + ID_W'(1);
                    end
                    OP_DECIDE:
                    begin
                        grant_reg <= 1'b0;
                        st_reg    <= id_bad ? ST_BAD_ID :
                                     ((req_reg == REQ_ASSIGN && none_free) ? ST_NONE : ST_OK);
                    end
                    OP_RD_UNIT:
                    begin
                        if (req_reg == REQ_FREE)
                        begin
                            if (!rd_taken)
                            begin
                                st_reg <= ST_WAS_FREE;
                            end
                            else
                            begin
                                if (head_reg[rd_type] == NIL_LINK)
                                begin
                                    head_reg[rd_type] <= {1'b0, id_reg};
                                end
                                tail_reg[rd_type] <= {1'b0, id_reg};
                            end
                        end
                        else
                        begin
                            u_reg <= rd_taken ? src_head[ID_W-1:0] : id_reg;
                        end
                    end
                    OP_UNLINK:
                    begin
                        grant_reg <= 1'b1;
                        if (rd_type != kind_reg)
                        begin
                            cnt_reg[kind_reg]  <= cnt_reg[kind_reg] + LINK_W'(1);
                            cnt_reg[~kind_reg] <= cnt_reg[~kind_reg] - LINK_W'(1);
                        end
                        if (rd_prev == NIL_LINK)
                        begin
                            head_reg[rd_type] <= rd_next;
                        end
                        if (rd_next == NIL_LINK)
                        begin
                            tail_reg[rd_type] <= rd_prev;
                        end
                    end
                    OP_RESULT:
                    begin
                        out_v_reg  <= 1'b1;
                        out_st_reg <= st_reg;
                        out_id_reg <= grant_reg ? u_reg : '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (start_ok)
            begin
                req_reg  <= req_type;
                id_reg   <= unit_id;
                kind_reg <= unit_kind;
            end
        end
    end

    assign stat.clear_done = (clr_reg == ID_W'(MAX_UNITS - 1));
    assign stat.error      = id_bad || (req_reg == REQ_ASSIGN && none_free);
    assign stat.is_free    = (req_reg == REQ_FREE);
    assign done            = out_v_reg;
    assign status          = out_st_reg;
    assign granted_id      = out_id_reg;
    assign count_kind_a    = cnt_reg[0];
    assign count_kind_b    = cnt_reg[1];

endmodule

>>> rtl/two_pool_server_allocator.sv
// Allocator for a pool of numbered units kept on two typed free lists.
// Issue a request by raising start while busy is low; the item is taken at
// that edge and busy then stays high through decide, read, unlink and
// result for an assign that grants a unit, through decide, read and result
// for a free (whether it releases the unit or finds it already free) and
// through decide and result for an invalid id or an assign with nothing
// free. These steps follow from the per-unit link memories, which give one
// registered read and one write per cycle. done pulses for one cycle right
// after busy drops, carrying the result; the receiver cannot stall results,
// and a new item may be accepted in that same cycle. After reset and after
// every accepted write of active_units a clearing pass over all MAX_UNITS
// (1024) entries runs with busy high. cfg_ready is high only while busy and
// start are both low, so a write never lands on an item in flight.
module two_pool_server_allocator
    import tpsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [ID_W-1:0]   unit_id,
    input  logic              unit_kind,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LINK_W-1:0] cfg_data,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   granted_id,
    output logic [LINK_W-1:0] count_kind_a,
    output logic [LINK_W-1:0] count_kind_b
);

    tpsa_cmd_t  cmd;
    tpsa_stat_t stat;
    logic       cfg_write;

    // A pool size write waits for an idle block with no item being offered.
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    tpsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_write (cfg_write),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    tpsa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_ok     (start && !busy),
        .req_type     (req_type),
        .unit_id      (unit_id),
        .unit_kind    (unit_kind),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .granted_id   (granted_id),
        .count_kind_a (count_kind_a),
        .count_kind_b (count_kind_b)
    );

    // A result only follows a request.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without request");

    // A result is a single-cycle pulse.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result held for more than one cycle");

    // Counts always sum to no more than the pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_kind_a) + 32'(count_kind_b) <= MAX_UNITS)
        else $error("count overflow");

endmodule
